FILE: hw/rtl/polynomial_evaluator_assert.svh
// ----------------------------------------------------------------------------
// Polynomial evaluator assertion macros
// Shorthand for clocked checks; clk and rst_n must be in scope.
// ----------------------------------------------------------------------------
`ifndef POLYNOMIAL_EVALUATOR_ASSERT_SVH
`define POLYNOMIAL_EVALUATOR_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define PE_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pipeline check failed");

// Consequent checked in the cycle after the antecedent.
`define PE_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pipeline check failed");

`endif

FILE: hw/rtl/pe_pkg.sv
// ----------------------------------------------------------------------------
// pe_pkg
// Widths, register indexes, pipeline types and saturation for the evaluator.
// ----------------------------------------------------------------------------
package pe_pkg;

    localparam int MAX_TERMS = 6;
    localparam int FRAC_BITS = 8;
    localparam int X_W       = 16;
    localparam int ACC_W     = 32;
    localparam int PROD_W    = X_W + ACC_W;
    localparam int WIDE_W    = PROD_W + 1;
    localparam int TC_W      = 3;
    localparam int CFG_IDX_W = 3;
    localparam int COEF_IDX_W = $clog2(MAX_TERMS);

    // Power starts at 1.0 in the wide format
    localparam logic signed [ACC_W-1:0] POWER_ONE = ACC_W'(1) <<< (2 * FRAC_BITS);

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TERM_COUNT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_FIRST = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_LAST  = CFG_IDX_W'(MAX_TERMS);

    typedef struct packed {
        logic signed [X_W-1:0]   x;
        logic signed [ACC_W-1:0] power;
        logic signed [ACC_W-1:0] sum;
        logic                    flag;
    } pe_data_t;

    typedef struct packed {
        logic term_on;   // coefficient of this stage is in use
        logic pow_on;    // a later term needs the next power
    } pe_term_ctl_t;

    typedef struct packed {
        logic                    ovf;
        logic signed [ACC_W-1:0] val;
    } pe_sat_t;

    function automatic pe_sat_t pe_sat(input logic signed [WIDE_W-1:0] v);
        pe_sat_t r;
        logic    hi_ones;
        logic    hi_zeros;
        hi_ones  = &v[WIDE_W-1:ACC_W-1];
        hi_zeros = ~|v[WIDE_W-1:ACC_W-1];
        r.ovf = !(hi_ones || hi_zeros);
        if (!r.ovf)
        begin
            r.val = v[ACC_W-1:0];
        end
        else if (v[WIDE_W-1])
        begin
            r.val = {1'b1, {(ACC_W-1){1'b0}}};
        end
        else
        begin
            r.val = {1'b0, {(ACC_W-1){1'b1}}};
        end
        return r;
    endfunction

endpackage

FILE: hw/rtl/pe_in_if.sv
// ----------------------------------------------------------------------------
// pe_in_if
// Sample channel: valid/ready with one Q8.8 evaluation point.
// ----------------------------------------------------------------------------
interface pe_in_if
    import pe_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic signed [X_W-1:0] x_value;

    modport source (output valid, output x_value, input ready);
    modport sink   (input valid, input x_value, output ready);
endinterface

FILE: hw/rtl/pe_out_if.sv
// ----------------------------------------------------------------------------
// pe_out_if
// Result channel: valid/ready with the Q16.16 value and the saturation flag.
// ----------------------------------------------------------------------------
interface pe_out_if
    import pe_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic signed [ACC_W-1:0] poly_value;
    logic                    saturated;

    modport source (output valid, output poly_value, output saturated, input ready);
    modport sink   (input valid, input poly_value, input saturated, output ready);
endinterface

FILE: hw/rtl/pe_term.sv
// ----------------------------------------------------------------------------
// pe_term
// One polynomial term: multiply stage, then accumulate/saturate stage.
// ----------------------------------------------------------------------------
`include "polynomial_evaluator_assert.svh"

module pe_term
    import pe_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  up_valid,
    output logic                  up_ready,
    input  pe_data_t              up_data,
    input  logic signed [X_W-1:0] coef,
    input  pe_term_ctl_t          ctl,
    output logic                  dn_valid,
    input  logic                  dn_ready,
    output pe_data_t              dn_data
);

    logic                     a_valid_reg;
    logic                     a_valid_next;
    pe_data_t                 a_data_reg;
    logic signed [PROD_W-1:0] prod_c_reg;
    logic signed [PROD_W-1:0] prod_p_reg;
    logic signed [PROD_W-1:0] prod_c_next;
    logic signed [PROD_W-1:0] prod_p_next;
    logic                     b_valid_reg;
    logic                     b_valid_next;
    pe_data_t                 b_data_reg;
    pe_data_t                 b_data_next;
    logic                     a_ready;
    logic                     b_ready;
    pe_sat_t                  sum_sat;
    pe_sat_t                  pow_sat;

    // Each stage takes new data when empty or when its content moves on
    assign b_ready  = !b_valid_reg || dn_ready;
    assign a_ready  = !a_valid_reg || b_ready;
    assign up_ready = a_ready;

    assign prod_c_next  = PROD_W'(coef) * PROD_W'(up_data.power);
    assign prod_p_next  = PROD_W'(up_data.power) * PROD_W'(up_data.x);
    assign a_valid_next = a_ready ? up_valid : a_valid_reg;
    assign b_valid_next = b_ready ? a_valid_reg : b_valid_reg;

    always_comb
    begin
        sum_sat = pe_sat(WIDE_W'(a_data_reg.sum) + WIDE_W'(prod_c_reg >>> FRAC_BITS));
        pow_sat = pe_sat(WIDE_W'(prod_p_reg >>> FRAC_BITS));
        b_data_next = a_data_reg;
        if (ctl.term_on)
        begin
            b_data_next.sum  = sum_sat.val;
            b_data_next.flag = b_data_next.flag | sum_sat.ovf;
        end
        if (ctl.pow_on)
        begin
            b_data_next.power = pow_sat.val;
            b_data_next.flag  = b_data_next.flag | pow_sat.ovf;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= a_valid_next;
            b_valid_reg <= b_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_ready && up_valid)
        begin
            a_data_reg <= up_data;
            prod_c_reg <= prod_c_next;
            prod_p_reg <= prod_p_next;
        end
        if (b_ready && a_valid_reg)
        begin
            b_data_reg <= b_data_next;
        end
    end

    assign dn_valid = b_valid_reg;
    assign dn_data  = b_data_reg;

    `PE_ASSERT_NEXT(a_holds, a_valid_reg && !b_ready, a_valid_reg && $stable(prod_c_reg))
    `PE_ASSERT_NEXT(b_holds, b_valid_reg && !dn_ready, b_valid_reg && $stable(b_data_reg))
    `PE_ASSERT_NOW(b_fills_from_a, $rose(b_valid_reg), $past(a_valid_reg))

endmodule

FILE: hw/rtl/polynomial_evaluator.sv
// ----------------------------------------------------------------------------
// polynomial_evaluator
// Fixed-point power-series evaluation, one term per pipeline pair of stages.
// ----------------------------------------------------------------------------
//  channel   direction  payload                         handshake
//  sample    in         x_value  (Q8.8)                 valid/ready
//  result    out        poly_value (Q16.16), saturated  valid/ready
//  cfg_*     in         cfg_index, cfg_data             cfg_we, no wait
//
//  One sample per cycle sustained while result is ready; two register stages
//  per term (multiply, then add and saturate) along the six-term chain.
//  Unused terms pass through their stages unchanged.
//  Each stage holds under backpressure and refills as soon as it empties.
//  Reset clears the valid bits, term_count to 1 and all coefficients to 0.
// ----------------------------------------------------------------------------
module polynomial_evaluator
    import pe_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    pe_in_if.sink                 sample,
    pe_out_if.source              result,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [X_W-1:0]        cfg_data
);

    logic [TC_W-1:0]       term_count_reg;
    logic signed [X_W-1:0] coef_reg [MAX_TERMS];
    logic [TC_W-1:0]       term_eff;
    pe_term_ctl_t          ctl [MAX_TERMS];
    logic                  st_valid [MAX_TERMS+1];
    logic                  st_ready [MAX_TERMS+1];
    pe_data_t              st_data  [MAX_TERMS+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            term_count_reg <= TC_W'(1);
            for (int i = 0; i < MAX_TERMS; i++)
            begin
                coef_reg[i] <= '0;
            end
        end
        else if (cfg_we)
        begin
            case (cfg_index) inside
                CFG_TERM_COUNT:
                begin
                    term_count_reg <= cfg_data[TC_W-1:0];
                end
                [CFG_COEF_FIRST:CFG_COEF_LAST]:
                begin
                    coef_reg[COEF_IDX_W'(cfg_index - CFG_COEF_FIRST)] <= cfg_data;
                end
                default:
                begin
                    // drop writes to unused indexes
                end
            endcase
        end
    end

    // Zero counts as one term, anything above the maximum as the maximum
    always_comb
    begin
        if (term_count_reg == '0)
        begin
            term_eff = TC_W'(1);
        end
        else if (term_count_reg > TC_W'(MAX_TERMS))
        begin
            term_eff = TC_W'(MAX_TERMS);
        end
        else
        begin
            term_eff = term_count_reg;
        end
    end

    assign st_valid[0]       = sample.valid;
    assign sample.ready      = st_ready[0];
    assign st_data[0].x      = sample.x_value;
    assign st_data[0].power  = POWER_ONE;
    assign st_data[0].sum    = '0;
    assign st_data[0].flag   = 1'b0;

    for (genvar k = 0; k < MAX_TERMS; k++)
    begin : g_term
        assign ctl[k].term_on = (TC_W'(k) < term_eff);
        assign ctl[k].pow_on  = (TC_W'(k + 1) < term_eff);

        pe_term u_term (
            .clk      (clk),
            .rst_n    (rst_n),
            .up_valid (st_valid[k]),
            .up_ready (st_ready[k]),
            .up_data  (st_data[k]),
            .coef     (coef_reg[k]),
            .ctl      (ctl[k]),
            .dn_valid (st_valid[k+1]),
            .dn_ready (st_ready[k+1]),
            .dn_data  (st_data[k+1])
        );
    end

    assign result.valid         = st_valid[MAX_TERMS];
    assign st_ready[MAX_TERMS]  = result.ready;
    assign result.poly_value    = st_data[MAX_TERMS].sum;
    assign result.saturated     = st_data[MAX_TERMS].flag;

endmodule
